### rtl/core/frame_checker_crc32_core_assert.svh
// Assertion macros for the frame checker core.
// Used by the bound checker; expects clk and rst_n in the including scope.
`ifndef FRAME_CHECKER_CRC32_CORE_ASSERT_SVH
`define FRAME_CHECKER_CRC32_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fcc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
// No dependencies; used by the result and config interfaces and all core modules.
package fcc_pkg;

  localparam int HDR_BYTES    = 32;
  localparam int HDR_CRC_SPAN = HDR_BYTES - 4;  // header bytes covered by the header CRC
  localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
  localparam int CNT_W        = 33;
  localparam int CRC_W        = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_TRUNC    = 3'd1;
  localparam status_t ST_MAGIC    = 3'd2;
  localparam status_t ST_VERSION  = 3'd3;
  localparam status_t ST_OVERSIZE = 3'd4;
  localparam status_t ST_HDR_CRC  = 3'd5;
  localparam status_t ST_PAY_CRC  = 3'd6;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MAGIC     = 2'd0;
  localparam reg_idx_t REG_VERSION   = 2'd1;
  localparam reg_idx_t REG_PAY_LIMIT = 2'd2;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [31:0] pay_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] msg_type;
    logic [31:0] flags;
    logic [31:0] session;
    logic [31:0] seq_num;
    logic [31:0] pay_len;
    logic [31:0] pay_crc;
    logic [31:0] hdr_crc;
  } hdr_t;

  // reflected CRC-32, one byte, bitwise
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // little-endian header, byte i at raw[8*i +: 8]
  function automatic hdr_t hdr_unpack(input logic [8*HDR_BYTES-1:0] raw);
    hdr_t h;
    h.magic    = raw[31:0];
    h.version  = raw[47:32];
    h.msg_type = raw[63:48];
    h.flags    = raw[95:64];
    h.session  = raw[127:96];
    h.seq_num  = raw[159:128];
    h.pay_len  = raw[191:160];
    h.pay_crc  = raw[223:192];
    h.hdr_crc  = raw[255:224];
    return h;
  endfunction

endpackage

### rtl/core/fcc_if.sv
// Valid/ready channel interfaces for the frame checker: byte input, result, config.
// Depends on fcc_pkg.
interface fcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface fcc_out_if;
  import fcc_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] msg_type;
  logic [31:0] frame_flags;
  logic [31:0] session_number;
  logic [31:0] sequence_number;
  logic [31:0] pay_len;
  logic [31:0] payload_crc;

  modport source (output valid, output status, output msg_type, output frame_flags,
                  output session_number, output sequence_number, output pay_len,
                  output payload_crc, input ready);
  modport sink   (input valid, input status, input msg_type, input frame_flags,
                  input session_number, input sequence_number, input pay_len,
                  input payload_crc, output ready);
endinterface

interface fcc_cfg_if;
  import fcc_pkg::*;
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/fcc_check.sv
// Final-byte status decision for the frame checker (priority chain of header checks).
// Depends on fcc_pkg.
module fcc_check (
  input  fcc_pkg::hdr_t              hdr,
  input  fcc_pkg::cfg_t              cfg,
  input  logic [fcc_pkg::CNT_W-1:0]  byte_cnt,
  input  logic [fcc_pkg::CRC_W-1:0]  hdr_crc_calc,
  input  logic [fcc_pkg::CRC_W-1:0]  pay_crc_calc,
  output fcc_pkg::status_t           status
);
  import fcc_pkg::*;

  logic [CNT_W-1:0] frame_len;

  assign frame_len = CNT_W'(HDR_BYTES) + {1'b0, hdr.pay_len};

  always_comb begin
    if (byte_cnt < CNT_W'(HDR_BYTES)) begin
      status = ST_TRUNC;
    end else if (hdr.magic != cfg.magic) begin
      status = ST_MAGIC;
    end else if (hdr.version != cfg.version) begin
      status = ST_VERSION;
    end else if (hdr.pay_len > cfg.pay_limit) begin
      status = ST_OVERSIZE;
    end else if (hdr_crc_calc != hdr.hdr_crc) begin
      status = ST_HDR_CRC;
    end else if (byte_cnt != frame_len) begin
      // a saturated count never matches, so it lands here too
      status = ST_TRUNC;
    end else if (pay_crc_calc != hdr.pay_crc) begin
      status = ST_PAY_CRC;
    end else begin
      status = ST_OK;
    end
  end

endmodule

### rtl/core/frame_checker_crc32_core.sv
// Frame checker top level: byte input register, header store, CRC-32 and result register.
// Depends on fcc_pkg, fcc_if (channel interfaces) and fcc_check.
//
// Takes one frame byte per cycle with no bubbles between bytes or frames, save
// while the input stalls as below. Each accepted byte sits in an input register;
// from there the one-byte CRC-32 update, the header capture, the byte count and,
// on the final byte, the status decision are done, and the result register loads
// as the byte advances. A result thus passes the input register and then the
// result register before it shows on out_ch. Input stalls only while a finished
// result waits in the output register and the next final byte is ready behind it.
// The header store needs no clearing after reset; the block is ready out of reset.
// Registers are written through cfg_ch and should only change while no frame is
// in flight.
module frame_checker_crc32_core (
  input logic       clk,
  input logic       rst_n,
  fcc_in_if.sink    in_ch,
  fcc_out_if.source out_ch,
  fcc_cfg_if.sink   cfg_ch
);
  import fcc_pkg::*;

  // configuration
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic     <= '0;
      cfg_r.version   <= 16'd1;
      cfg_r.pay_limit <= 32'd65536;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MAGIC:     cfg_r.magic     <= cfg_ch.data;
        REG_VERSION:   cfg_r.version   <= cfg_ch.data[15:0];
        REG_PAY_LIMIT: cfg_r.pay_limit <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input register
  logic       stg_v_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       out_v_r;
  logic       stall;
  logic       advance;

  assign stall       = stg_v_r && stg_last_r && out_v_r && !out_ch.ready;
  assign advance     = stg_v_r && !stall;
  assign in_ch.ready = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (!stall) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && !stall) begin
      stg_byte_r <= in_ch.data_byte;
      stg_last_r <= in_ch.frame_end;
    end
  end

  // frame state
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [CRC_W-1:0] crc_r,  crc_nxt;
  logic [CRC_W-1:0] hcrc_r, hcrc_nxt;
  logic [7:0]       hdr_r   [HDR_BYTES];
  logic [7:0]       hdr_nxt [HDR_BYTES];
  logic [CRC_W-1:0] crc_upd;
  logic             in_hdr;
  logic [HDR_IDX_W-1:0]   hdr_idx;
  logic [8*HDR_BYTES-1:0] hdr_raw;
  hdr_t             hdr;
  status_t          status;

  assign crc_upd = crc_byte(crc_r, stg_byte_r);
  assign in_hdr  = cnt_r < CNT_W'(HDR_BYTES);
  assign hdr_idx = cnt_r[HDR_IDX_W-1:0];
  assign cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    crc_nxt  = crc_r;
    hcrc_nxt = hcrc_r;
    if (cnt_r < CNT_W'(HDR_CRC_SPAN)) begin
      if (cnt_r == CNT_W'(HDR_CRC_SPAN - 1)) begin
        // header CRC done; restart for the payload
        hcrc_nxt = crc_upd ^ CRC_ONES;
        crc_nxt  = CRC_ONES;
      end else begin
        crc_nxt = crc_upd;
      end
    end else if (!in_hdr) begin
      crc_nxt = crc_upd;
    end
    // stored header CRC bytes themselves are not covered
  end

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_nxt[i] = (in_hdr && hdr_idx == HDR_IDX_W'(i)) ? stg_byte_r : hdr_r[i];
      hdr_raw[8*i +: 8] = hdr_nxt[i];
    end
  end

  assign hdr = hdr_unpack(hdr_raw);

  fcc_check u_check (
    .hdr          (hdr),
    .cfg          (cfg_r),
    .byte_cnt     (cnt_nxt),
    .hdr_crc_calc (hcrc_nxt),
    .pay_crc_calc (crc_nxt ^ CRC_ONES),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      crc_r  <= CRC_ONES;
      hcrc_r <= '0;
    end else if (advance) begin
      if (stg_last_r) begin
        cnt_r  <= '0;
        crc_r  <= CRC_ONES;
        hcrc_r <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        crc_r  <= crc_nxt;
        hcrc_r <= hcrc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hdr_r <= hdr_nxt;
    end
  end

  // result register
  status_t     res_status_r;
  logic [15:0] res_type_r;
  logic [31:0] res_flags_r;
  logic [31:0] res_session_r;
  logic [31:0] res_seq_r;
  logic [31:0] res_len_r;
  logic [31:0] res_pcrc_r;
  logic        short_frame;

  assign short_frame = cnt_nxt < CNT_W'(HDR_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && stg_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg_last_r) begin
      res_status_r <= status;
      if (short_frame) begin
        res_type_r    <= '0;
        res_flags_r   <= '0;
        res_session_r <= '0;
        res_seq_r     <= '0;
        res_len_r     <= '0;
        res_pcrc_r    <= '0;
      end else begin
        res_type_r    <= hdr.msg_type;
        res_flags_r   <= hdr.flags;
        res_session_r <= hdr.session;
        res_seq_r     <= hdr.seq_num;
        res_len_r     <= hdr.pay_len;
        res_pcrc_r    <= hdr.pay_crc;
      end
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.status          = res_status_r;
  assign out_ch.msg_type        = res_type_r;
  assign out_ch.frame_flags     = res_flags_r;
  assign out_ch.session_number  = res_session_r;
  assign out_ch.sequence_number = res_seq_r;
  assign out_ch.pay_len         = res_len_r;
  assign out_ch.payload_crc     = res_pcrc_r;

endmodule

### rtl/core/fcc_checker.sv
// Port-level checks for the frame checker core, attached by bind.
// Depends on fcc_pkg and frame_checker_crc32_core_assert.svh.
`include "frame_checker_crc32_core_assert.svh"

module fcc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_frame_end,
  input logic             out_valid,
  input logic             out_ready,
  input fcc_pkg::status_t out_status,
  input logic [31:0]      out_payload_crc
);
  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // result word holds while stalled
  `FCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_status) && $stable(out_payload_crc),
                  "result word changed while stalled")

  // final byte gives a result through the input and result registers
  `FCC_ASSERT_IMP(a_result_due, $past(in_acc && in_frame_end && rst_n, 2) && $past(rst_n),
                  out_valid, "no result two cycles after final byte")

  // no result appears without a final byte
  `FCC_ASSERT_IMP(a_no_spurious, $rose(out_valid), $past(in_acc && in_frame_end, 2),
                  "result without a final byte")

  // input only stalls behind a waiting result
  `FCC_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready,
                  "input stalled while output free")

endmodule

bind frame_checker_crc32_core fcc_checker u_fcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_frame_end    (in_ch.frame_end),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_payload_crc (out_ch.payload_crc)
);
